// ===== src/cqs_pkg.sv =====
// Shared constants, command codes and inter-module types of the constant-Q spectrum block.
package cqs_pkg;

	localparam int MAX_WINDOW   = 16384;
	localparam int WP_W         = $clog2(MAX_WINDOW);
	localparam int NUM_BUCKETS  = 64;
	localparam int BK_W         = $clog2(NUM_BUCKETS);
	localparam int BC_W         = 7;
	localparam int KERNEL_DEPTH = 262144;
	localparam int KA_W         = $clog2(KERNEL_DEPTH);
	localparam int WL_W         = 15;
	localparam int SMP_W        = 16;
	localparam int COEF_W       = 32;
	localparam int ACC_W        = 64;
	localparam int DB_W         = 16;
	localparam int PIX_W        = 8;
	localparam int DR_W         = 15;
	localparam int HOP_W        = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [1:0] CMD_LOAD_LEN  = 2'd0;
	localparam logic [1:0] CMD_LOAD_KERN = 2'd1;
	localparam logic [1:0] CMD_SAMPLE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LEN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_AMP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DYN_RANGE    = 3'd4;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] sum_sin;
		logic signed [ACC_W-1:0] sum_cos;
	} cqs_mac_res_t;

	typedef struct packed {
		logic                   done;
		logic signed [DB_W-1:0] level_db;
		logic [PIX_W-1:0]       pixel;
	} cqs_post_res_t;

endpackage

// ===== src/cqs_ifs.sv =====
// Valid/ready channel interfaces: request, result and configuration write.
interface cqs_req_if import cqs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               cmd;
	logic [KA_W-1:0]          index;
	logic [WL_W-1:0]          window_len;
	logic signed [COEF_W-1:0] coef_sin;
	logic signed [COEF_W-1:0] coef_cos;
	logic signed [SMP_W-1:0]  sample;

	modport source(output valid, cmd, index, window_len, coef_sin, coef_cos, sample,
		input ready);
	modport sink(input valid, cmd, index, window_len, coef_sin, coef_cos, sample,
		output ready);
endinterface

interface cqs_rsp_if import cqs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [BK_W-1:0]        bucket;
	logic signed [DB_W-1:0] level_db;
	logic [PIX_W-1:0]       pixel;
	logic                   last;

	modport source(output valid, bucket, level_db, pixel, last, input ready);
	modport sink(input valid, bucket, level_db, pixel, last, output ready);
endinterface

interface cqs_cfg_if import cqs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  idx;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

// ===== src/cqs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module cqs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/cqs_mac.sv =====
// Kernel correlation engine: streams window and kernel reads, multiplies and accumulates.
module cqs_mac import cqs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [WP_W-1:0]         start_addr,
	input  logic [KA_W-1:0]         base,
	input  logic [WL_W-1:0]         len,
	output logic [WP_W-1:0]         samp_addr,
	output logic [KA_W-1:0]         kern_addr,
	input  logic signed [SMP_W-1:0] samp_rdata,
	input  logic [2*COEF_W-1:0]     kern_rdata,
	output cqs_mac_res_t            res
);

	logic                    busy_q;
	logic                    done_q;
	logic [WL_W-1:0]         n_q;
	logic [WL_W-1:0]         len_q;
	logic [WP_W-1:0]         start_q;
	logic [KA_W-1:0]         base_q;
	logic                    vld_s1;
	logic                    vld_s2;
	logic signed [47:0]      psin_s2;
	logic signed [47:0]      pcos_s2;
	logic signed [ACC_W-1:0] asin_q;
	logic signed [ACC_W-1:0] acos_q;
	logic                    issue;
	logic signed [47:0]      psin;
	logic signed [47:0]      pcos;

	assign issue     = busy_q && (n_q != len_q);
	assign samp_addr = start_q + n_q[WP_W-1:0];
	assign kern_addr = base_q + KA_W'(n_q);
	assign psin      = samp_rdata * $signed(kern_rdata[2*COEF_W-1:COEF_W]);
	assign pcos      = samp_rdata * $signed(kern_rdata[COEF_W-1:0]);

	always_comb begin
		res.done    = done_q;
		res.sum_sin = asin_q;
		res.sum_cos = acos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			n_q    <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (start) begin
				busy_q <= 1'b1;
				n_q    <= '0;
			end else if (issue) begin
				n_q <= n_q + 1'b1;
			end else if (busy_q && !vld_s1 && !vld_s2) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			len_q   <= len;
			start_q <= start_addr;
			base_q  <= base;
			asin_q  <= '0;
			acos_q  <= '0;
		end else if (vld_s2) begin
			asin_q <= asin_q + ACC_W'(psin_s2);
			acos_q <= acos_q + ACC_W'(pcos_s2);
		end
		psin_s2 <= psin;
		pcos_s2 <= pcos;
	end

endmodule

// ===== src/cqs_post.sv =====
// Magnitude to dB and gray level: scaling, squaring, iterative log2, dB scale, pixel divide.
module cqs_post import cqs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  cqs_mac_res_t            sums,
	input  logic signed [DB_W-1:0]  max_amp,
	input  logic [DR_W-1:0]         dyn_range,
	output cqs_post_res_t           res
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_ABS  = 4'd1;
	localparam logic [3:0] ST_SHF  = 4'd2;
	localparam logic [3:0] ST_SQA  = 4'd3;
	localparam logic [3:0] ST_SQB  = 4'd4;
	localparam logic [3:0] ST_CHK  = 4'd5;
	localparam logic [3:0] ST_NORM = 4'd6;
	localparam logic [3:0] ST_LOG  = 4'd7;
	localparam logic [3:0] ST_DB1  = 4'd8;
	localparam logic [3:0] ST_DB2  = 4'd9;
	localparam logic [3:0] ST_PIX  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;

	localparam logic signed [18:0] DB_SCALE = 19'sd197283;
	localparam logic signed [43:0] DB_HALF  = 44'sd8388608;

	logic [3:0]              state_q;
	logic                    done_q;
	logic [ACC_W-1:0]        aa_q;
	logic [ACC_W-1:0]        bb_q;
	logic [5:0]              s_q;
	logic [63:0]             p_q;
	logic [5:0]              e_q;
	logic [30:0]             m_q;
	logic [15:0]             frac_q;
	logic [3:0]              it_q;
	logic signed [43:0]      prod_q;
	logic signed [DB_W-1:0]  db_q;
	logic [PIX_W-1:0]        pix_q;
	logic [24:0]             num_q;
	logic [24:0]             den_q;

	logic [ACC_W-1:0]        mx;
	logic [30:0]             sq_in;
	logic [61:0]             sq;
	logic [61:0]             mm;
	logic [31:0]             t;
	logic signed [8:0]       ex;
	logic signed [24:0]      l16;
	logic signed [43:0]      dbm;
	logic signed [43:0]      yr;
	logic signed [18:0]      d;
	logic [24:0]             dsh;

	assign mx    = (aa_q > bb_q) ? aa_q : bb_q;
	assign sq_in = (state_q == ST_SQA) ? aa_q[30:0] : bb_q[30:0];
	assign sq    = sq_in * sq_in;
	assign mm    = m_q * m_q;
	assign t     = mm[61:30];
	assign ex    = $signed({3'b0, e_q}) + $signed({2'b0, s_q, 1'b0}) - 9'sd92;
	assign l16   = {ex, frac_q};
	assign dbm   = l16 * DB_SCALE;
	assign yr    = (prod_q + DB_HALF) >>> 24;
	assign d     = 19'(db_q) - 19'(max_amp) + $signed({4'b0, dyn_range});
	assign dsh   = den_q << it_q[2:0];

	always_comb begin
		res.done     = done_q;
		res.level_db = db_q;
		res.pixel    = pix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_SHF;
				ST_SHF:  if (mx[ACC_W-1:31] == '0) state_q <= ST_SQA;
				ST_SQA:  state_q <= ST_SQB;
				ST_SQB:  state_q <= ST_CHK;
				ST_CHK: begin
					if (p_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: if (p_q[63]) state_q <= ST_LOG;
				ST_LOG:  if (it_q == '0) state_q <= ST_DB1;
				ST_DB1:  state_q <= ST_DB2;
				ST_DB2:  state_q <= ST_PIX;
				ST_PIX: begin
					if (d <= 0 || d >= $signed({4'b0, dyn_range})) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (it_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_ABS: begin
				aa_q <= sums.sum_sin[ACC_W-1] ? ACC_W'(-sums.sum_sin) : sums.sum_sin;
				bb_q <= sums.sum_cos[ACC_W-1] ? ACC_W'(-sums.sum_cos) : sums.sum_cos;
				s_q  <= '0;
			end
			ST_SHF: begin
				if (mx[ACC_W-1:31] != '0) begin
					aa_q <= aa_q >> 1;
					bb_q <= bb_q >> 1;
					s_q  <= s_q + 1'b1;
				end
			end
			ST_SQA: p_q <= {2'b0, sq};
			ST_SQB: p_q <= p_q + {2'b0, sq};
			ST_CHK: begin
				e_q   <= 6'd63;
				db_q  <= -16'sd32768;
				pix_q <= '0;
			end
			ST_NORM: begin
				if (!p_q[63]) begin
					p_q <= p_q << 1;
					e_q <= e_q - 1'b1;
				end else begin
					m_q    <= p_q[63:33];
					it_q   <= 4'd15;
					frac_q <= '0;
				end
			end
			ST_LOG: begin
				frac_q[it_q] <= t[31];
				m_q          <= t[31] ? t[31:1] : t[30:0];
				it_q         <= it_q - 1'b1;
			end
			ST_DB1: prod_q <= dbm;
			ST_DB2: begin
				if (yr < -44'sd32768) begin
					db_q <= -16'sd32768;
				end else if (yr > 44'sd32767) begin
					db_q <= 16'sd32767;
				end else begin
					db_q <= yr[DB_W-1:0];
				end
			end
			ST_PIX: begin
				pix_q <= (d >= $signed({4'b0, dyn_range})) ? 8'd255 : 8'd0;
				num_q <= 25'(d[14:0]) * 25'd510 + 25'(dyn_range);
				den_q <= 25'({dyn_range, 1'b0});
				it_q  <= 4'd7;
			end
			ST_DIV: begin
				if (num_q >= dsh) begin
					num_q            <= num_q - dsh;
					pix_q[it_q[2:0]] <= 1'b1;
				end
				it_q <= it_q - 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== src/constant_q_spectrum_frame.sv =====
// Constant-Q spectrum frame generator top level: command decode, memories and frame sequencer.
//
// Channels: req carries commands (load bucket window length, load kernel pair,
// audio sample); rsp carries one result per bucket, bucket 0 first, last set on
// the final bucket of a frame; cfg writes the five configuration registers.
// After reset the block zeroes all 16384 entries of the sample window, one entry
// per cycle; req.ready stays low during that sweep, cfg is always ready.
// Table loads and samples that fire no frame leave the block idle and ready for the next request.
// A sample that completes a frame starts the bucket sequencer: per bucket a
// multiply-accumulate loop (one window and one kernel memory read per cycle)
// and then the dB/pixel unit, whose run time is set mainly by its scale,
// normalize, 16-step log2 and 8-step divide loops.
// req.ready is low while a frame is in work. Each result sits in an output
// register; if rsp is stalled the sequencer holds the next bucket until that
// register is taken. After the last bucket the block accepts input again while
// the final result still waits.
module constant_q_spectrum_frame import cqs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	cqs_req_if.sink   req,
	cqs_rsp_if.source rsp,
	cqs_cfg_if.sink   cfg
);

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_LEN   = 3'd2;
	localparam logic [2:0] ST_SETUP = 3'd3;
	localparam logic [2:0] ST_MAC   = 3'd4;
	localparam logic [2:0] ST_POST  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0]             state_q;
	logic [WP_W-1:0]        clr_cnt_q;
	logic [WP_W-1:0]        wp_q;
	logic [HOP_W-1:0]       ssf_q;
	logic                   ffd_q;
	logic [BC_W-1:0]        k_q;
	logic [KA_W-1:0]        base_q;
	logic [WL_W-1:0]        raw_len_q;

	logic [BC_W-1:0]        bucket_count_q;
	logic [WL_W-1:0]        window_max_q;
	logic [HOP_W-1:0]       hop_len_q;
	logic signed [DB_W-1:0] max_amp_q;
	logic [DR_W-1:0]        dyn_range_q;

	logic                   out_vld_q;
	logic [BK_W-1:0]        out_bucket_q;
	logic signed [DB_W-1:0] out_db_q;
	logic [PIX_W-1:0]       out_pix_q;
	logic                   out_last_q;

	logic                   acc;
	logic [WL_W-1:0]        wm;
	logic [HOP_W-1:0]       hop;
	logic [BC_W-1:0]        cnt;
	logic [DR_W-1:0]        dr;
	logic [HOP_W-1:0]       ssf_next;
	logic [HOP_W-1:0]       need;
	logic                   fire;
	logic                   emit;
	logic                   last_bkt;

	logic                   swin_we;
	logic [WP_W-1:0]        swin_waddr;
	logic [SMP_W-1:0]       swin_wdata;
	logic [WP_W-1:0]        swin_raddr;
	logic [SMP_W-1:0]       swin_rdata;
	logic                   kern_we;
	logic [KA_W-1:0]        kern_raddr;
	logic [2*COEF_W-1:0]    kern_rdata;
	logic                   blen_we;
	logic [WL_W-1:0]        blen_rdata;

	logic [WL_W-1:0]        wl_eff;
	logic [WL_W-1:0]        off;
	logic [WP_W-1:0]        start_addr;
	cqs_mac_res_t           mac_res;
	cqs_post_res_t          post_res;

	assign acc     = req.valid && req.ready;
	assign wm      = (window_max_q < 15'd2) ? 15'd2 :
		(window_max_q > WL_W'(MAX_WINDOW)) ? WL_W'(MAX_WINDOW) : window_max_q;
	assign hop     = (hop_len_q == '0) ? 16'd1 : hop_len_q;
	assign cnt     = (bucket_count_q == '0) ? 7'd1 :
		(bucket_count_q > BC_W'(NUM_BUCKETS)) ? BC_W'(NUM_BUCKETS) : bucket_count_q;
	assign dr      = (dyn_range_q == '0) ? 15'd1 : dyn_range_q;

	assign ssf_next = (ssf_q == '1) ? ssf_q : ssf_q + 1'b1;
	assign need     = ffd_q ? hop : HOP_W'(wm - (wm >> 1));
	assign fire     = ssf_next >= need;

	assign emit     = (state_q == ST_EMIT) && (!out_vld_q || rsp.ready);
	assign last_bkt = (k_q + 1'b1) == cnt;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid    = out_vld_q;
	assign rsp.bucket   = out_bucket_q;
	assign rsp.level_db = out_db_q;
	assign rsp.pixel    = out_pix_q;
	assign rsp.last     = out_last_q;

	assign swin_we    = (state_q == ST_CLR) || (acc && req.cmd == CMD_SAMPLE);
	assign swin_waddr = (state_q == ST_CLR) ? clr_cnt_q : wp_q;
	assign swin_wdata = (state_q == ST_CLR) ? '0 : req.sample;
	assign kern_we    = acc && req.cmd == CMD_LOAD_KERN;
	assign blen_we    = acc && req.cmd == CMD_LOAD_LEN && req.index < KA_W'(NUM_BUCKETS);

	assign wl_eff     = (blen_rdata > wm) ? wm : blen_rdata;
	assign off        = (wm - wl_eff) >> 1;
	assign start_addr = wp_q - wm[WP_W-1:0] + off[WP_W-1:0];

	cqs_ram #(.WIDTH(SMP_W), .DEPTH(MAX_WINDOW)) u_swin (
		.clk   (clk),
		.we    (swin_we),
		.waddr (swin_waddr),
		.wdata (swin_wdata),
		.raddr (swin_raddr),
		.rdata (swin_rdata)
	);

	cqs_ram #(.WIDTH(2*COEF_W), .DEPTH(KERNEL_DEPTH)) u_kern (
		.clk   (clk),
		.we    (kern_we),
		.waddr (req.index),
		.wdata ({req.coef_sin, req.coef_cos}),
		.raddr (kern_raddr),
		.rdata (kern_rdata)
	);

	cqs_ram #(.WIDTH(WL_W), .DEPTH(NUM_BUCKETS)) u_blen (
		.clk   (clk),
		.we    (blen_we),
		.waddr (req.index[BK_W-1:0]),
		.wdata (req.window_len),
		.raddr (k_q[BK_W-1:0]),
		.rdata (blen_rdata)
	);

	cqs_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == ST_SETUP),
		.start_addr (start_addr),
		.base       (base_q),
		.len        (wl_eff),
		.samp_addr  (swin_raddr),
		.kern_addr  (kern_raddr),
		.samp_rdata ($signed(swin_rdata)),
		.kern_rdata (kern_rdata),
		.res        (mac_res)
	);

	cqs_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     ((state_q == ST_MAC) && mac_res.done),
		.sums      (mac_res),
		.max_amp   (max_amp_q),
		.dyn_range (dr),
		.res       (post_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= 7'd64;
			window_max_q   <= 15'd16384;
			hop_len_q      <= 16'd500;
			max_amp_q      <= '0;
			dyn_range_q    <= 15'd25600;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.idx)
				REG_BUCKET_COUNT: bucket_count_q <= cfg.data[BC_W-1:0];
				REG_WINDOW_MAX:   window_max_q   <= cfg.data[WL_W-1:0];
				REG_HOP_LEN:      hop_len_q      <= cfg.data;
				REG_MAX_AMP:      max_amp_q      <= $signed(cfg.data);
				REG_DYN_RANGE:    dyn_range_q    <= cfg.data[DR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_cnt_q <= '0;
			wp_q      <= '0;
			ssf_q     <= '0;
			ffd_q     <= 1'b0;
			k_q       <= '0;
			base_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc && req.cmd == CMD_SAMPLE) begin
						wp_q <= wp_q + 1'b1;
						if (fire) begin
							ffd_q   <= 1'b1;
							ssf_q   <= '0;
							k_q     <= '0;
							base_q  <= '0;
							state_q <= ST_LEN;
						end else begin
							ssf_q <= ssf_next;
						end
					end
				end
				ST_LEN:   state_q <= ST_SETUP;
				ST_SETUP: state_q <= ST_MAC;
				ST_MAC:   if (mac_res.done) state_q <= ST_POST;
				ST_POST:  if (post_res.done) state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit) begin
						base_q  <= base_q + KA_W'(raw_len_q);
						k_q     <= k_q + 1'b1;
						state_q <= last_bkt ? ST_IDLE : ST_LEN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			raw_len_q <= blen_rdata;
		end
		if (emit) begin
			out_bucket_q <= k_q[BK_W-1:0];
			out_db_q     <= post_res.level_db;
			out_pix_q    <= post_res.pixel;
			out_last_q   <= last_bkt;
		end
	end

endmodule
